// ===== sv/brtc_pkg.sv =====
// Shared types and constants for the banked RTC register block.
package brtc_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  address;
      logic [7:0]  write_data;
      logic [23:0] tick_clocks;
      logic [5:0]  now_seconds;
      logic [5:0]  now_minutes;
      logic [4:0]  now_hours;
      logic [2:0]  now_weekday;
      logic [4:0]  now_day;
      logic [3:0]  now_month;
      logic [6:0]  now_year;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       second_irq;
      logic       sixteenth_irq;
   } rsp_type;

   localparam logic [4:0]  ADR_CONTROL  = 5'h1B;
   localparam logic [4:0]  ADR_TEST     = 5'h1D;
   localparam logic [4:0]  ADR_PIN_MASK = 5'h1F;
   localparam logic [4:0]  ADR_LEAP     = 5'h17;

   localparam int          ALARM_DEPTH  = 13;

   localparam logic [23:0] SECOND_PERIOD_RESET    = 24'd10000000;
   localparam logic [23:0] SIXTEENTH_PERIOD_RESET = 24'd625000;

   localparam logic [3:0]  PIN_MASK_RESET = 4'hC;

endpackage

// ===== sv/brtc_regs.sv =====
// Register file: control, test, pin mask and alarm bank, plus read decode.
module brtc_regs
   import brtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_en,
   input  req_type    item,
   output logic [7:0] read_data,
   output logic [3:0] pin_mask
);

   logic [3:0] alarm_ff [ALARM_DEPTH];
   logic [3:0] control_ff, control_in;
   logic [3:0] test_ff, test_in;
   logic [3:0] pin_mask_ff, pin_mask_in;

   logic [3:0] idx;
   logic       is_write;
   logic       alarm_we;

   // bank-1 write masks; entries 9 and 12 always hold 0
   function automatic logic [3:0] alarm_mask(input logic [3:0] i);
      logic [3:0] m;
      begin
         case (i)
            4'd0:    m = 4'h7;
            4'd1:    m = 4'h1;
            4'd2:    m = 4'hF;
            4'd3:    m = 4'h7;
            4'd4:    m = 4'hF;
            4'd5:    m = 4'h3;
            4'd6:    m = 4'h7;
            4'd7:    m = 4'hF;
            4'd8:    m = 4'h3;
            4'd10:   m = 4'h1;
            4'd11:   m = 4'h3;
            default: m = 4'h0;
         endcase
         return m;
      end
   endfunction

   // divide by ten through reciprocal 205/2048, exact for values below 1029
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      begin
         p = 15'(v) * 15'd205;
         return p[14:11];
      end
   endfunction

   function automatic logic [3:0] mod10(input logic [6:0] v);
      logic [3:0] q;
      logic [6:0] r;
      begin
         q = div10(v);
         r = v - 7'(q) * 7'd10;
         return r[3:0];
      end
   endfunction

   assign idx      = item.address[4:1];
   assign is_write = item_en && (opcode_type'(item.opcode) == OP_WRITE) && item.address[0];
   assign alarm_we = is_write && control_ff[0] && (item.address != ADR_CONTROL)
                     && (item.address != ADR_TEST) && (item.address != ADR_PIN_MASK)
                     && (idx < 4'(ALARM_DEPTH));

   always_comb begin
      control_in  = control_ff;
      test_in     = test_ff;
      pin_mask_in = pin_mask_ff;
      if (is_write) begin
         if (item.address == ADR_CONTROL)  control_in  = item.write_data[3:0] & 4'hD;
         if (item.address == ADR_TEST)     test_in     = item.write_data[3:0];
         if (item.address == ADR_PIN_MASK) pin_mask_in = item.write_data[3:0] & 4'hC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= '0;
         test_ff     <= '0;
         pin_mask_ff <= PIN_MASK_RESET;
         for (int i = 0; i < ALARM_DEPTH; i++) alarm_ff[i] <= '0;
      end else begin
         control_ff  <= control_in;
         test_ff     <= test_in;
         pin_mask_ff <= pin_mask_in;
         if (alarm_we) alarm_ff[idx] <= item.write_data[3:0] & alarm_mask(idx);
      end
   end

   always_comb begin
      logic [3:0] lo;
      lo = '0;
      if (!item.address[0]) begin
         read_data = 8'hFF;
      end else begin
         if (item.address == ADR_CONTROL) begin
            lo = control_ff & 4'hD;
         end else if (item.address == ADR_TEST) begin
            lo = test_ff;
         end else if (item.address == ADR_PIN_MASK) begin
            lo = pin_mask_ff;
         end else if (!control_ff[0]) begin
            case (idx)
               4'd0:    lo = mod10(7'(item.now_seconds));
               4'd1:    lo = div10(7'(item.now_seconds));
               4'd2:    lo = mod10(7'(item.now_minutes));
               4'd3:    lo = div10(7'(item.now_minutes));
               4'd4:    lo = mod10(7'(item.now_hours));
               4'd5:    lo = div10(7'(item.now_hours));
               4'd6:    lo = 4'(item.now_weekday);
               4'd7:    lo = mod10(7'(item.now_day));
               4'd8:    lo = div10(7'(item.now_day));
               4'd9:    lo = mod10(7'(item.now_month));
               4'd10:   lo = div10(7'(item.now_month));
               4'd11:   lo = mod10(item.now_year);
               default: lo = div10(item.now_year);
            endcase
         end else if (item.address == ADR_LEAP) begin
            lo = {2'b00, item.now_year[1:0]};
         end else if (idx < 4'(ALARM_DEPTH)) begin
            lo = alarm_ff[idx];
         end
         read_data = {4'hF, lo};
      end
   end

   assign pin_mask = pin_mask_ff;

endmodule

// ===== sv/brtc_accum.sv =====
// Saturating clock accumulator with period compare and one subtract.
module brtc_accum
(
   input  logic        clock,
   input  logic        reset,
   input  logic        tick_en,
   input  logic [23:0] add,
   input  logic [23:0] period,
   output logic        fire
);

   logic [31:0] acc_ff, acc_in;
   logic [32:0] sum;
   logic [31:0] sat;

   assign sum  = {1'b0, acc_ff} + {9'b0, add};
   assign sat  = sum[32] ? '1 : sum[31:0];
   assign fire = sat >= {8'b0, period};

   always_comb begin
      acc_in = acc_ff;
      if (tick_en) acc_in = fire ? sat - {8'b0, period} : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== sv/banked_rtc_register_block_top.sv =====
// Top level: input register, register file, two accumulators, result register.
//
// Banked RTC register block. Each word on req_ is a register read, a register write or a
// clock tick; every word returns exactly one rsp_ word, in order. One word is taken per
// cycle unless req_stall is high; the result word is held in the input register, then in the
// result register, and is presented on rsp_. The per-item path is the 32-bit saturating add,
// period compare and subtract of the tick accumulators, which update in the same cycle as
// the result is registered. Periods are written through csr_ (index 0 one-second, index 1
// sixteen-hertz) only while idle, a rule on the user that the block itself does not enforce.
module banked_rtc_register_block_top
   import brtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_word,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   logic        in_valid_ff;
   req_type     in_word_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_word_ff, rsp_word_in;

   logic [23:0] second_period_ff;
   logic [23:0] sixteenth_period_ff;

   logic        out_ready;
   logic        advance;
   logic        tick_en;
   logic [7:0]  read_data;
   logic [3:0]  pin_mask;
   logic        second_fire;
   logic        sixteenth_fire;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign tick_en   = advance && (opcode_type'(in_word_ff.opcode) == OP_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         second_period_ff    <= SECOND_PERIOD_RESET;
         sixteenth_period_ff <= SIXTEENTH_PERIOD_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == 1'b0) second_period_ff    <= csr_write_data;
         else                   sixteenth_period_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_word_ff <= req_word;
   end

   brtc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .item_en   (advance),
      .item      (in_word_ff),
      .read_data (read_data),
      .pin_mask  (pin_mask)
   );

   brtc_accum u_second (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .add     (in_word_ff.tick_clocks),
      .period  (second_period_ff),
      .fire    (second_fire)
   );

   brtc_accum u_sixteenth (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .add     (in_word_ff.tick_clocks),
      .period  (sixteenth_period_ff),
      .fire    (sixteenth_fire)
   );

   always_comb begin
      rsp_word_in = '0;
      case (opcode_type'(in_word_ff.opcode))
         OP_READ: rsp_word_in.read_data = read_data;
         OP_TICK: begin
            rsp_word_in.second_irq    = second_fire && !pin_mask[3];
            rsp_word_in.sixteenth_irq = sixteenth_fire && !pin_mask[2];
         end
         default: rsp_word_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
